@@ src/gsbu_pkg.sv @@
// Shared constants and types of the gzip stored-block unpacker.
`timescale 1ns / 1ps
`default_nettype none

package gsbu_pkg;

  localparam int unsigned OUTQ_DEPTH = 4;

  localparam logic [3:0] PH_FIXED   = 4'd0;
  localparam logic [3:0] PH_XLEN    = 4'd1;
  localparam logic [3:0] PH_XSKIP   = 4'd2;
  localparam logic [3:0] PH_NAME    = 4'd3;
  localparam logic [3:0] PH_COMMENT = 4'd4;
  localparam logic [3:0] PH_HCRC    = 4'd5;
  localparam logic [3:0] PH_BLOCK   = 4'd6;
  localparam logic [3:0] PH_CHUNK   = 4'd7;
  localparam logic [3:0] PH_DATA    = 4'd8;
  localparam logic [3:0] PH_ERROR   = 4'd9;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_HDR_CUT   = 3'd3;
  localparam logic [2:0] ST_NOT_STORED = 3'd4;
  localparam logic [2:0] ST_NLEN      = 3'd5;
  localparam logic [2:0] ST_OVERRUN   = 3'd6;
  localparam logic [2:0] ST_SIZE      = 3'd7;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [7:0] MAGIC0         = 8'h1F;
  localparam logic [7:0] MAGIC1         = 8'h8B;
  localparam logic [7:0] METHOD_DEFLATE = 8'h08;
  localparam logic [1:0] BTYPE_STORED   = 2'b00;
  localparam logic [4:0] MIN_STREAM_LEN = 5'd18;
  localparam logic [4:0] SEEN_MAX       = 5'd31;
  localparam logic [3:0] FIXED_HDR_LAST = 4'd9;
  localparam logic [3:0] FLG_INDEX      = 4'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic       pay_vld;
    logic [7:0] pay_data;
    logic       stat_vld;
    logic [2:0] stat_code;
  } parse_res_t;

endpackage

`default_nettype wire

@@ src/gsbu_parser.sv @@
// Trailer delay line, header and chunk parser and final status of one stream.
`timescale 1ns / 1ps
`default_nettype none

module gsbu_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_vld,
  input  wire logic [7:0]        item_byte,
  input  wire logic              item_last,
  output gsbu_pkg::parse_res_t   res
);

  logic [7:0]  tail_r [8];
  logic [7:0]  tail_nxt [8];
  logic [3:0]  tail_fill_r, tail_fill_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [23:0] chdr_r, chdr_nxt;
  logic [1:0]  cfill_r, cfill_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] total_r, total_nxt;
  logic [4:0]  seen_r, seen_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        shift_en;
  logic [7:0]  old_byte;
  logic        pay_hit;
  logic [15:0] skip_full;
  logic [31:0] isize;
  logic [2:0]  status;

  function automatic logic [3:0] next_part(input logic [3:0] p, input logic [3:0] f);
    logic [3:0] r;
    r = gsbu_pkg::PH_BLOCK;
    if (p <= gsbu_pkg::PH_HCRC && f[3]) r = gsbu_pkg::PH_HCRC;
    if (p <= gsbu_pkg::PH_COMMENT && f[2]) r = gsbu_pkg::PH_COMMENT;
    if (p <= gsbu_pkg::PH_NAME && f[1]) r = gsbu_pkg::PH_NAME;
    if (p <= gsbu_pkg::PH_XLEN && f[0]) r = gsbu_pkg::PH_XLEN;
    return r;
  endfunction

  assign shift_en  = tail_fill_r[3];
  assign old_byte  = tail_r[0];
  assign skip_full = {old_byte, skip_r[7:0]};
  assign isize     = {item_byte, tail_r[7], tail_r[6], tail_r[5]};

  always_comb begin
    tail_nxt      = tail_r;
    tail_fill_nxt = tail_fill_r;
    phase_nxt     = phase_r;
    hidx_nxt      = hidx_r;
    flags_nxt     = flags_r;
    skip_nxt      = skip_r;
    chdr_nxt      = chdr_r;
    cfill_nxt     = cfill_r;
    left_nxt      = left_r;
    total_nxt     = total_r;
    err_nxt       = err_r;
    pay_hit       = 1'b0;
    seen_nxt      = (seen_r == gsbu_pkg::SEEN_MAX) ? seen_r : seen_r + 5'd1;

    if (shift_en) begin
      for (int k = 0; k < 7; k++) begin
        tail_nxt[k] = tail_r[k + 1];
      end
      tail_nxt[7] = item_byte;
    end else begin
      tail_nxt[tail_fill_r[2:0]] = item_byte;
      tail_fill_nxt = tail_fill_r + 4'd1;
    end

    if (shift_en) begin
      case (phase_r)
        gsbu_pkg::PH_FIXED: begin
          if ((hidx_r == 4'd0 && old_byte != gsbu_pkg::MAGIC0) ||
              (hidx_r == 4'd1 && old_byte != gsbu_pkg::MAGIC1) ||
              (hidx_r == 4'd2 && old_byte != gsbu_pkg::METHOD_DEFLATE)) begin
            err_nxt   = (err_r == gsbu_pkg::ST_OK) ? gsbu_pkg::ST_BAD_MAGIC : err_r;
            phase_nxt = gsbu_pkg::PH_ERROR;
          end else begin
            if (hidx_r == gsbu_pkg::FLG_INDEX) begin
              flags_nxt = {old_byte[1], old_byte[4], old_byte[3], old_byte[2]};
            end
            if (hidx_r == gsbu_pkg::FIXED_HDR_LAST) begin
              hidx_nxt  = 4'd0;
              phase_nxt = next_part(gsbu_pkg::PH_XLEN, flags_nxt);
            end else begin
              hidx_nxt = hidx_r + 4'd1;
            end
          end
        end
        gsbu_pkg::PH_XLEN: begin
          if (hidx_r == 4'd0) begin
            skip_nxt = {8'd0, old_byte};
            hidx_nxt = 4'd1;
          end else begin
            skip_nxt = skip_full;
            hidx_nxt = 4'd0;
            if (skip_full == 16'd0) begin
              phase_nxt = next_part(gsbu_pkg::PH_NAME, flags_r);
            end else begin
              phase_nxt = gsbu_pkg::PH_XSKIP;
            end
          end
        end
        gsbu_pkg::PH_XSKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_r == 16'd1) begin
            hidx_nxt  = 4'd0;
            phase_nxt = next_part(gsbu_pkg::PH_NAME, flags_r);
          end
        end
        gsbu_pkg::PH_NAME: begin
          if (old_byte == 8'd0) begin
            hidx_nxt  = 4'd0;
            phase_nxt = next_part(gsbu_pkg::PH_COMMENT, flags_r);
          end
        end
        gsbu_pkg::PH_COMMENT: begin
          if (old_byte == 8'd0) begin
            hidx_nxt  = 4'd0;
            phase_nxt = next_part(gsbu_pkg::PH_HCRC, flags_r);
          end
        end
        gsbu_pkg::PH_HCRC: begin
          if (hidx_r == 4'd1) begin
            hidx_nxt  = 4'd0;
            phase_nxt = gsbu_pkg::PH_BLOCK;
          end else begin
            hidx_nxt = hidx_r + 4'd1;
          end
        end
        gsbu_pkg::PH_BLOCK: begin
          if (old_byte[2:1] != gsbu_pkg::BTYPE_STORED) begin
            err_nxt   = (err_r == gsbu_pkg::ST_OK) ? gsbu_pkg::ST_NOT_STORED : err_r;
            phase_nxt = gsbu_pkg::PH_ERROR;
          end else begin
            phase_nxt = gsbu_pkg::PH_CHUNK;
            chdr_nxt  = 24'd0;
            cfill_nxt = 2'd0;
          end
        end
        gsbu_pkg::PH_CHUNK: begin
          case (cfill_r)
            2'd0: begin
              chdr_nxt[7:0] = old_byte;
              cfill_nxt     = 2'd1;
            end
            2'd1: begin
              chdr_nxt[15:8] = old_byte;
              cfill_nxt      = 2'd2;
            end
            2'd2: begin
              chdr_nxt[23:16] = old_byte;
              cfill_nxt       = 2'd3;
            end
            default: begin
              chdr_nxt  = 24'd0;
              cfill_nxt = 2'd0;
              if (~chdr_r[15:0] != {old_byte, chdr_r[23:16]}) begin
                err_nxt   = (err_r == gsbu_pkg::ST_OK) ? gsbu_pkg::ST_NLEN : err_r;
                phase_nxt = gsbu_pkg::PH_ERROR;
              end else if (chdr_r[15:0] != 16'd0) begin
                left_nxt  = chdr_r[15:0];
                phase_nxt = gsbu_pkg::PH_DATA;
              end
            end
          endcase
        end
        gsbu_pkg::PH_DATA: begin
          pay_hit   = 1'b1;
          total_nxt = total_r + 32'd1;
          left_nxt  = left_r - 16'd1;
          if (left_r == 16'd1) begin
            phase_nxt = gsbu_pkg::PH_CHUNK;
          end
        end
        default: begin
        end
      endcase
    end

    if (seen_nxt < gsbu_pkg::MIN_STREAM_LEN) begin
      status = gsbu_pkg::ST_SHORT;
    end else if (err_nxt != gsbu_pkg::ST_OK) begin
      status = err_nxt;
    end else if (phase_nxt <= gsbu_pkg::PH_BLOCK) begin
      status = gsbu_pkg::ST_HDR_CUT;
    end else if (phase_nxt == gsbu_pkg::PH_DATA) begin
      status = gsbu_pkg::ST_OVERRUN;
    end else if (total_nxt == isize) begin
      status = gsbu_pkg::ST_OK;
    end else begin
      status = gsbu_pkg::ST_SIZE;
    end
  end

  assign res.pay_vld   = item_vld & pay_hit;
  assign res.pay_data  = old_byte;
  assign res.stat_vld  = item_vld & item_last;
  assign res.stat_code = status;

  always_ff @(posedge clk) begin
    if (item_vld) begin
      tail_r   <= tail_nxt;
      skip_r   <= skip_nxt;
      chdr_r   <= chdr_nxt;
      cfill_r  <= cfill_nxt;
      left_r   <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_fill_r <= 4'd0;
      phase_r     <= gsbu_pkg::PH_FIXED;
      hidx_r      <= 4'd0;
      flags_r     <= 4'd0;
      total_r     <= 32'd0;
      seen_r      <= 5'd0;
      err_r       <= gsbu_pkg::ST_OK;
    end else if (item_vld) begin
      if (item_last) begin
        tail_fill_r <= 4'd0;
        phase_r     <= gsbu_pkg::PH_FIXED;
        hidx_r      <= 4'd0;
        flags_r     <= 4'd0;
        total_r     <= 32'd0;
        seen_r      <= 5'd0;
        err_r       <= gsbu_pkg::ST_OK;
      end else begin
        tail_fill_r <= tail_fill_nxt;
        phase_r     <= phase_nxt;
        hidx_r      <= hidx_nxt;
        flags_r     <= flags_nxt;
        total_r     <= total_nxt;
        seen_r      <= seen_nxt;
        err_r       <= err_nxt;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && item_last |=> phase_r == gsbu_pkg::PH_FIXED && tail_fill_r == 4'd0)
    else $error("Parser state not cleared after the final byte.");

  a_pay_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    res.pay_vld |-> phase_r == gsbu_pkg::PH_DATA && tail_fill_r == 4'd8)
    else $error("Payload byte emitted outside the data phase.");

  a_err_parks: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != gsbu_pkg::ST_OK |-> phase_r == gsbu_pkg::PH_ERROR)
    else $error("Error recorded while the parser is still running.");

endmodule

`default_nettype wire

@@ src/gsbu_outq.sv @@
// Small result queue that takes up to two results per cycle and sends one per cycle while not stalled.
`timescale 1ns / 1ps
`default_nettype none

module gsbu_outq #(
  parameter int unsigned DEPTH = gsbu_pkg::OUTQ_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [1:0]            wr_cnt,
  input  wire gsbu_pkg::res_item_t   wr_item0,
  input  wire gsbu_pkg::res_item_t   wr_item1,
  output logic                       room2,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output gsbu_pkg::res_item_t        out_item
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ROOM2_MAX = CW'(DEPTH - 2);
  localparam logic [PW-1:0] LAST_IDX  = PW'(DEPTH - 1);

  gsbu_pkg::res_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  assign pop       = out_valid & ~out_stall;
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign room2     = (count_r <= ROOM2_MAX);
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (wr_cnt == 2'd1) wr_ptr_nxt = wr_ptr_p1;
    if (wr_cnt == 2'd2) wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(wr_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem_r[wr_ptr_r] <= wr_item0;
    if (wr_cnt == 2'd2) mem_r[wr_ptr_p1] <= wr_item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && wr_cnt == 2'd0 |=> count_r == $past(count_r) - CW'(1))
    else $error("Queue count wrong after a pop.");

  a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
    !pop && wr_cnt == 2'd2 |=> count_r == $past(count_r) + CW'(2))
    else $error("Queue count wrong after a double push.");

endmodule

`default_nettype wire

@@ src/gzip_stored_block_unpacker.sv @@
// Top level of the gzip stored-block unpacker: input register, parser and result queue.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    in_byte, in_last
//   out_     output     out_valid / out_stall  out_kind, out_byte, out_status, out_last
//
// One stream byte is accepted per cycle while the input is not stalled; its results pass
// through the input register and the result queue before they can be taken.
// A final byte that also releases a payload byte yields two results, the payload byte first.
// The input stalls while a byte waits in the input register and the result queue has fewer
// than two free entries.
// Reset is synchronous and returns the parser to the start of a stream.
// After each final byte the parser clears itself for the next stream.
`timescale 1ns / 1ps
`default_nettype none

module gzip_stored_block_unpacker #(
  parameter int unsigned QUEUE_DEPTH = gsbu_pkg::OUTQ_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_kind,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_status,
  output logic            out_last
);

  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  logic                  in_last_r;
  logic                  room2;
  logic                  consume;
  logic                  take;
  gsbu_pkg::parse_res_t  pres;
  gsbu_pkg::res_item_t   pay_item, stat_item, item0, out_item;
  logic [1:0]            wr_cnt;

  assign consume  = in_vld_r & room2;
  assign in_stall = in_vld_r & ~room2;
  assign take     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take) begin
      in_vld_r <= 1'b1;
    end else if (consume) begin
      in_vld_r <= 1'b0;
    end
  end

  gsbu_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (consume),
    .item_byte (in_byte_r),
    .item_last (in_last_r),
    .res       (pres)
  );

  always_comb begin
    pay_item.kind    = gsbu_pkg::KIND_PAYLOAD;
    pay_item.data    = pres.pay_data;
    pay_item.status  = gsbu_pkg::ST_OK;
    pay_item.last    = 1'b0;
    stat_item.kind   = gsbu_pkg::KIND_STATUS;
    stat_item.data   = 8'd0;
    stat_item.status = pres.stat_code;
    stat_item.last   = 1'b1;
    item0  = pres.pay_vld ? pay_item : stat_item;
    wr_cnt = {1'b0, pres.pay_vld} + {1'b0, pres.stat_vld};
  end

  gsbu_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_cnt    (wr_cnt),
    .wr_item0  (item0),
    .wr_item1  (stat_item),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_kind   = out_item.kind;
  assign out_byte   = out_item.data;
  assign out_status = out_item.status;
  assign out_last   = out_item.last;

endmodule

`default_nettype wire
